// File: rtl/line_pixel_generator_unit_macros.svh
// Assertion macros shared by the line pixel generator RTL.
`ifndef LINE_PIXEL_GENERATOR_UNIT_MACROS_SVH
`define LINE_PIXEL_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line pixel generator check failed");

// Next-cycle implication, checked outside reset.
`define LPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line pixel generator check failed");

`endif

// File: rtl/lpg_pkg.sv
// Shared types and constants of the line pixel generator.
package lpg_pkg;

   // Coordinate width used inside the block, and the fixed port width.
   localparam int COORD_BITS = 6;
   localparam int PORT_BITS  = 6;
   // Decision term needs room for twice a span plus a sign.
   localparam int DEC_BITS   = COORD_BITS + 3;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic signed [DEC_BITS-1:0] dec_type;

   // Walk parameters worked out from one pair of endpoints.
   typedef struct packed {
      coord_type major_start;
      coord_type minor_start;
      coord_type span;
      dec_type   decision;
      dec_type   step_straight;
      dec_type   step_diagonal;
      logic      swap;
      logic      major_dec;
      logic      minor_dec;
   } lpg_init_type;

   // One pixel as presented by the walker.
   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } lpg_pixel_type;

   // Sequencer commands to the walker.
   typedef struct packed {
      logic load;
      logic advance;
   } lpg_walk_ctrl_type;

endpackage

// File: rtl/lpg_setup.sv
// Endpoint ordering, octant folding and Bresenham term setup.
module lpg_setup (
   input  lpg_pkg::coord_type    x0,
   input  lpg_pkg::coord_type    y0,
   input  lpg_pkg::coord_type    x1,
   input  lpg_pkg::coord_type    y1,
   output lpg_pkg::lpg_init_type init
);
   import lpg_pkg::*;

   logic      straight;
   logic      vert;
   logic      order_swap;
   coord_type ax0, ay0, ax1, ay1;
   logic      falling;
   coord_type adx, ady;
   logic      steep;
   coord_type lo, hi;
   coord_type dmaj, dmin;
   dec_type   dmaj_s, dmin_s;

   always_comb begin
      straight = (x0 == x1) || (y0 == y1);
      vert     = (x0 == x1);

      // Order the endpoints so that x rises.
      order_swap = x0 > x1;
      ax0 = order_swap ? x1 : x0;
      ay0 = order_swap ? y1 : y0;
      ax1 = order_swap ? x0 : x1;
      ay1 = order_swap ? y0 : y1;

      // Spans of the general line after the y mirror.
      falling = ay0 > ay1;
      adx     = ax1 - ax0;
      ady     = falling ? (ay0 - ay1) : (ay1 - ay0);
      steep   = ady > adx;

      // Bounds of a straight line along its varying axis.
      if (vert) begin
         lo = (y0 < y1) ? y0 : y1;
         hi = (y0 < y1) ? y1 : y0;
      end else begin
         lo = (x0 < x1) ? x0 : x1;
         hi = (x0 < x1) ? x1 : x0;
      end

      if (straight) begin
         // A straight line never takes a minor step: its decision stays at minus the span, never positive.
         init.swap        = vert;
         init.major_dec   = 1'b0;
         init.minor_dec   = 1'b0;
         init.major_start = lo;
         init.minor_start = vert ? x0 : y0;
         dmaj             = hi - lo;
         dmin             = '0;
      end else begin
         init.swap        = steep;
         init.major_dec   = steep & falling;
         init.minor_dec   = ~steep & falling;
         init.major_start = steep ? ay0 : ax0;
         init.minor_start = steep ? ax0 : ay0;
         dmaj             = steep ? ady : adx;
         dmin             = steep ? adx : ady;
      end

      dmaj_s = signed'({{(DEC_BITS-COORD_BITS){1'b0}}, dmaj});
      dmin_s = signed'({{(DEC_BITS-COORD_BITS){1'b0}}, dmin});

      init.span          = dmaj;
      init.step_straight = dmin_s <<< 1;
      init.step_diagonal = (dmin_s - dmaj_s) <<< 1;
      init.decision      = (dmin_s <<< 1) - dmaj_s;
   end

endmodule

// File: rtl/lpg_walker.sv
// Bresenham stepping unit: one shared decision adder, one pixel per step.
module lpg_walker (
   input  logic                       clock,
   input  logic                       reset,
   input  lpg_pkg::lpg_walk_ctrl_type ctrl,
   input  lpg_pkg::lpg_init_type      init,
   output lpg_pkg::lpg_pixel_type     pixel
);
   import lpg_pkg::*;

   coord_type major_ff, major_in;
   coord_type minor_ff, minor_in;
   coord_type count_ff, count_in;
   dec_type   decision_ff, decision_in;
   dec_type   step_straight_ff, step_straight_in;
   dec_type   step_diagonal_ff, step_diagonal_in;
   logic      swap_ff, swap_in;
   logic      major_dec_ff, major_dec_in;
   logic      minor_dec_ff, minor_dec_in;

   dec_type   dec_sum;
   logic      go_diag;
   logic      last;

   // Current pixel mapped back to screen axes.
   always_comb begin
      last        = (count_ff == '0);
      pixel.last  = last;
      pixel.x     = swap_ff ? minor_ff : major_ff;
      pixel.y     = swap_ff ? major_ff : minor_ff;
   end

   // Shared adder: the decision picks which increment it takes.
   always_comb begin
      go_diag = ~decision_ff[DEC_BITS-1];
      dec_sum = decision_ff + (go_diag ? step_diagonal_ff : step_straight_ff);
   end

   // Next state: load a new walk, or take one step.
   always_comb begin
      major_in         = major_ff;
      minor_in         = minor_ff;
      count_in         = count_ff;
      decision_in      = decision_ff;
      step_straight_in = step_straight_ff;
      step_diagonal_in = step_diagonal_ff;
      swap_in          = swap_ff;
      major_dec_in     = major_dec_ff;
      minor_dec_in     = minor_dec_ff;
      if (ctrl.load) begin
         major_in         = init.major_start;
         minor_in         = init.minor_start;
         count_in         = init.span;
         decision_in      = init.decision;
         step_straight_in = init.step_straight;
         step_diagonal_in = init.step_diagonal;
         swap_in          = init.swap;
         major_dec_in     = init.major_dec;
         minor_dec_in     = init.minor_dec;
      end else if (ctrl.advance && !last) begin
         major_in    = major_dec_ff ? (major_ff - coord_type'(1))
                                    : (major_ff + coord_type'(1));
         count_in    = count_ff - coord_type'(1);
         decision_in = dec_sum;
         if (go_diag) begin
            minor_in = minor_dec_ff ? (minor_ff - coord_type'(1))
                                    : (minor_ff + coord_type'(1));
         end
      end
   end

   // Walk registers; the step terms are payload and need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff     <= '0;
         minor_ff     <= '0;
         count_ff     <= '0;
         decision_ff  <= '0;
         swap_ff      <= 1'b0;
         major_dec_ff <= 1'b0;
         minor_dec_ff <= 1'b0;
      end else begin
         major_ff     <= major_in;
         minor_ff     <= minor_in;
         count_ff     <= count_in;
         decision_ff  <= decision_in;
         swap_ff      <= swap_in;
         major_dec_ff <= major_dec_in;
         minor_dec_ff <= minor_dec_in;
      end
   end

   always_ff @(posedge clock) begin
      step_straight_ff <= step_straight_in;
      step_diagonal_ff <= step_diagonal_in;
   end

endmodule

// File: rtl/line_pixel_generator_unit.sv
// Top level of the line pixel generator: sequencer, endpoint capture, result register.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_start_x, req_start_y, req_end_x, req_end_y
//   rsp     | out       | rsp_valid/rsp_stall | rsp_pixel_x, rsp_pixel_y, rsp_last_pixel
//
// A line of N pixels (N = major span + 1, up to 64) occupies the block while it captures the
// endpoints, sets up the walker and then registers each pixel in turn.
// The walker's single decision adder gives one pixel per cycle unless the output stalls.
// Reset is synchronous and active high; it empties the result register and idles the block.
// An output stall freezes the walker; req_stall stays high until the last pixel is registered.
module line_pixel_generator_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [lpg_pkg::PORT_BITS-1:0] req_start_x,
   input  logic [lpg_pkg::PORT_BITS-1:0] req_start_y,
   input  logic [lpg_pkg::PORT_BITS-1:0] req_end_x,
   input  logic [lpg_pkg::PORT_BITS-1:0] req_end_y,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [lpg_pkg::PORT_BITS-1:0] rsp_pixel_x,
   output logic [lpg_pkg::PORT_BITS-1:0] rsp_pixel_y,
   output logic                      rsp_last_pixel
);
   import lpg_pkg::*;
   `include "line_pixel_generator_unit_macros.svh"

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;

   logic [1:0]        state_ff, state_in;
   coord_type         x0_ff, y0_ff, x1_ff, y1_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   coord_type         rsp_x_ff, rsp_y_ff;
   logic              rsp_last_ff;
   logic              req_take;
   logic              slot_free;
   logic              emit;
   lpg_init_type      init;
   lpg_pixel_type     pixel;
   lpg_walk_ctrl_type walk_ctrl;

   lpg_setup u_setup (
      .x0   (x0_ff),
      .y0   (y0_ff),
      .x1   (x1_ff),
      .y1   (y1_ff),
      .init (init)
   );

   lpg_walker u_walker (
      .clock (clock),
      .reset (reset),
      .ctrl  (walk_ctrl),
      .init  (init),
      .pixel (pixel)
   );

   // Handshake decode.
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      req_take  = req_valid && !req_stall;
      slot_free = !rsp_valid_ff || !rsp_stall;
      emit      = (state_ff == ST_WALK) && slot_free;
      walk_ctrl.load    = (state_ff == ST_SETUP);
      walk_ctrl.advance = emit;
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (emit && pixel.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register valid: set on a new pixel, cleared once the pixel is taken downstream.
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Endpoint capture, masked to the working coordinate width.
   always_ff @(posedge clock) begin
      if (req_take) begin
         x0_ff <= req_start_x[COORD_BITS-1:0];
         y0_ff <= req_start_y[COORD_BITS-1:0];
         x1_ff <= req_end_x[COORD_BITS-1:0];
         y1_ff <= req_end_y[COORD_BITS-1:0];
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_x_ff    <= pixel.x;
         rsp_y_ff    <= pixel.y;
         rsp_last_ff <= pixel.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = PORT_BITS'(rsp_x_ff);
   assign rsp_pixel_y    = PORT_BITS'(rsp_y_ff);
   assign rsp_last_pixel = rsp_last_ff;

   // An accepted transaction always goes to walker setup.
   `LPG_ASSERT_NEXT(a_take_to_setup, clock, reset, req_take, state_ff == ST_SETUP)
   // Registering the final pixel returns the sequencer to idle with the mark set.
   `LPG_ASSERT_NEXT(a_last_to_idle, clock, reset, emit && pixel.last,
                    (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff)
   // A new result only appears out of the walking state.
   `LPG_ASSERT_NOW(a_rsp_from_walk, clock, reset, $rose(rsp_valid_ff),
                   $past(state_ff) == ST_WALK)

endmodule
